@@ hdl/mrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_pkg
// shared types and constants of the modbus rtu slave engine
// ----------------------------------------------------------------------------
package mrs_pkg;

	localparam logic [1:0] OP_RX    = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_SETIN = 2'd2;
	localparam logic [1:0] OP_RDHLD = 2'd3;

	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_ADDR   = 2'd1;
	localparam logic [1:0] CFG_CTO    = 2'd2;
	localparam logic [1:0] CFG_FDLY   = 2'd3;

	localparam logic [7:0] FN_READ_HOLD  = 8'd3;
	localparam logic [7:0] FN_READ_INPUT = 8'd4;
	localparam logic [7:0] FN_WRITE_HOLD = 8'd16;
	localparam logic [7:0] EXC_FUNCTION  = 8'd1;
	localparam logic [7:0] EXC_ADDRESS   = 8'd2;
	localparam logic [7:0] EXC_VALUE     = 8'd3;
	localparam logic [7:0] EXC_FLAG      = 8'h80;
	localparam logic [15:0] MAX_READ_QTY  = 16'd125;
	localparam logic [15:0] MAX_WRITE_QTY = 16'd123;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RX,
		ST_TICK,
		ST_CRC_RD,
		ST_CRC_BYTE,
		ST_CRC_BIT,
		ST_HDR_RD,
		ST_HDR_LAT,
		ST_CHK_RD,
		ST_CHK_LAT,
		ST_DECODE,
		ST_WR_RD,
		ST_WR_LAT,
		ST_WR_RD2,
		ST_WR_LAT2,
		ST_TX_SEL,
		ST_TX_OUT,
		ST_RDBACK
	} state_t;

	typedef enum logic [2:0] {
		TXS_ADDR,
		TXS_FN,
		TXS_B2,
		TXS_DATA,
		TXS_CRCL,
		TXS_CRCH
	} tx_sel_t;

	// controller to datapath
	typedef struct packed {
		logic       frame_clear;  // count, overflow, silence to zero
		logic       store_byte;
		logic       tick;
		logic       gap_set;
		logic       gap_clr;
		logic       act_set;
		logic       act_clr;
		logic       crc_init;
		logic       crc_byte;     // xor byte into crc
		logic       crc_bit;      // one shift step
		logic       rd_req;       // memory read at rd_addr
		logic [8:0] rd_addr;
		logic [2:0] hdr_slot;     // latch read byte into header slot
		logic       hdr_lat;
		logic       wlat_hi;
		logic       wlat_lo;
		logic       hold_wr;
		logic [4:0] hold_idx;
		logic       setin;
		logic       out_load;
		logic       out_kind;
		logic [7:0] out_byte;
		logic       out_last;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic        enable;
		logic        active;
		logic        gap;
		logic        overflow;
		logic [8:0]  count;
		logic        cto_hit;
		logic        fdly_hit;
		logic [15:0] crc;
		logic [7:0]  rd_byte;
		logic [7:0]  slave_addr;
		logic [7:0]  fn;
		logic [15:0] start;
		logic [15:0] qty;
		logic [15:0] crc_rx;
		logic [15:0] table_word;
		logic [15:0] wr_word;
		logic        out_full;
	} dp_sts_t;

endpackage

@@ hdl/mrs_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_in_if / mrs_out_if
// valid/ready channels for items and results
// ----------------------------------------------------------------------------
interface mrs_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  rx_byte;
	logic [4:0]  reg_index;
	logic [15:0] reg_value;
	modport source(output valid, operation, rx_byte, reg_index, reg_value, input ready);
	modport sink(input valid, operation, rx_byte, reg_index, reg_value, output ready);
endinterface

interface mrs_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  tx_byte;
	logic [15:0] holding_value;
	logic        last;
	modport source(output valid, result_kind, tx_byte, holding_value, last, input ready);
	modport sink(input valid, result_kind, tx_byte, holding_value, last, output ready);
endinterface

@@ hdl/mrs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_ram
// generic single-port write, single read ram with registered read
// ----------------------------------------------------------------------------
module mrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/mrs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_datapath
// frame store, timers, crc unit, register tables and result register
// ----------------------------------------------------------------------------
module mrs_datapath #(
	parameter int FRAME_BYTES = 256,
	parameter int NUM_HOLDING = 2,
	parameter int NUM_INPUT   = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [7:0]          in_byte,
	input  logic [4:0]          in_idx,
	input  logic [15:0]         in_val,
	input  logic                in_fn_hold,   // table select for reads
	input  mrs_pkg::dp_cmd_t    cmd,
	output mrs_pkg::dp_sts_t    sts,
	mrs_out_if.source           res
);
	localparam int AW = $clog2(FRAME_BYTES);

	logic        enable_q;
	logic [7:0]  addr_q;
	logic [15:0] cto_q, fdly_q;
	logic [8:0]  count_q;
	logic        ovf_q, gap_q, act_q;
	logic [15:0] sil_q, crc_q;
	logic [7:0]  rd_q;
	logic        rd_ok_q;
	logic [7:0]  hdr_q [8];
	logic [7:0]  whi_q, wlo_q;
	logic [15:0] hold_q [NUM_HOLDING];
	logic [15:0] inp_q [NUM_INPUT];
	logic [7:0]  ram_rd;
	logic [15:0] sil_nx;
	logic [4:0]  tidx;
	logic [15:0] tword;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			addr_q   <= 8'd1;
			cto_q    <= 16'd750;
			fdly_q   <= 16'd1750;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrs_pkg::CFG_ENABLE: enable_q <= cfg_data[0];
				mrs_pkg::CFG_ADDR:   addr_q   <= cfg_data[7:0];
				mrs_pkg::CFG_CTO:    cto_q    <= cfg_data;
				mrs_pkg::CFG_FDLY:   fdly_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sil_nx = (sil_q == 16'hFFFF) ? sil_q : sil_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			sil_q   <= '0;
			gap_q   <= 1'b0;
			act_q   <= 1'b0;
		end else begin
			if (cmd.tick) sil_q <= sil_nx;
			if (cmd.store_byte) begin
				sil_q <= '0;
				if (count_q < 9'(FRAME_BYTES)) count_q <= count_q + 9'd1;
				else ovf_q <= 1'b1;
			end
			if (cmd.frame_clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				sil_q   <= '0;
			end
			if (cmd.gap_set) gap_q <= 1'b1;
			if (cmd.gap_clr) gap_q <= 1'b0;
			if (cmd.act_set) act_q <= 1'b1;
			if (cmd.act_clr) act_q <= 1'b0;
		end
	end

	mrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_store (
		.clk  (clk),
		.we   (cmd.store_byte && count_q < 9'(FRAME_BYTES)),
		.waddr(count_q[AW-1:0]),
		.wdata(in_byte),
		.raddr(cmd.rd_addr[AW-1:0]),
		.rdata(ram_rd)
	);

	// bytes past the received length read as zero
	always_ff @(posedge clk) begin
		if (cmd.rd_req) rd_ok_q <= (cmd.rd_addr < count_q) && (cmd.rd_addr < 9'(FRAME_BYTES));
	end
	assign rd_q = rd_ok_q ? ram_rd : 8'd0;

	always_ff @(posedge clk) begin
		if (cmd.crc_init) crc_q <= mrs_pkg::CRC_INIT;
		else if (cmd.crc_byte) crc_q <= crc_q ^ {8'd0, cmd.out_byte};
		else if (cmd.crc_bit)
			crc_q <= crc_q[0] ? ((crc_q >> 1) ^ mrs_pkg::CRC_POLY) : (crc_q >> 1);
		if (cmd.hdr_lat) hdr_q[cmd.hdr_slot] <= rd_q;
		if (cmd.wlat_hi) whi_q <= rd_q;
		if (cmd.wlat_lo) wlo_q <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_HOLDING; i++) hold_q[i] <= '0;
			for (int i = 0; i < NUM_INPUT; i++) inp_q[i] <= '0;
		end else begin
			for (int i = 0; i < NUM_HOLDING; i++)
				if (cmd.hold_wr && cmd.hold_idx == 5'(i)) hold_q[i] <= {whi_q, wlo_q};
			for (int i = 0; i < NUM_INPUT; i++)
				if (cmd.setin && in_idx == 5'(i)) inp_q[i] <= in_val;
		end
	end

	assign tidx = cmd.hold_idx;
	always_comb begin
		tword = '0;
		if (in_fn_hold) begin
			for (int i = 0; i < NUM_HOLDING; i++) if (tidx == 5'(i)) tword = hold_q[i];
		end else begin
			for (int i = 0; i < NUM_INPUT; i++) if (tidx == 5'(i)) tword = inp_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res.valid <= 1'b0;
		else if (cmd.out_load) res.valid <= 1'b1;
		else if (res.ready) res.valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res.result_kind   <= cmd.out_kind;
			res.tx_byte       <= cmd.out_kind ? 8'd0 : cmd.out_byte;
			res.holding_value <= cmd.out_kind ? tword : 16'd0;
			res.last          <= cmd.out_last;
		end
	end

	assign sts.table_word = tword;
	assign sts.enable     = enable_q;
	assign sts.active     = act_q;
	assign sts.gap        = gap_q;
	assign sts.overflow   = ovf_q;
	assign sts.count      = count_q;
	assign sts.cto_hit    = sil_nx >= cto_q;
	assign sts.fdly_hit   = sil_nx >= fdly_q;
	assign sts.crc        = crc_q;
	assign sts.rd_byte    = rd_q;
	assign sts.slave_addr = addr_q;
	assign sts.fn         = hdr_q[1];
	assign sts.start      = {hdr_q[2], hdr_q[3]};
	assign sts.qty        = {hdr_q[4], hdr_q[5]};
	assign sts.crc_rx     = {hdr_q[7], hdr_q[6]};
	assign sts.wr_word    = {whi_q, wlo_q};
	assign sts.out_full   = res.valid && !res.ready;
endmodule

@@ hdl/mrs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrs_ctrl
// sequencer for item handling, frame check and response generation
// ----------------------------------------------------------------------------
module mrs_ctrl #(
	parameter int NUM_HOLDING = 2,
	parameter int NUM_INPUT   = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       in_op,
	output logic             fn_hold,
	input  mrs_pkg::dp_sts_t sts,
	output mrs_pkg::dp_cmd_t cmd
);
	mrs_pkg::state_t  st_q, st_d;
	mrs_pkg::tx_sel_t sel_q, sel_d;
	logic [8:0]  ptr_q, ptr_d;     // store address or byte counter
	logic [8:0]  len_q, len_d;     // bytes before crc
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  b2_q, b2_d;       // third tx byte
	logic [7:0]  fno_q, fno_d;     // tx function byte
	logic [6:0]  wi_q, wi_d;       // word index
	logic [6:0]  nw_q, nw_d;       // word count
	logic        dat_q, dat_d;     // data mode: 0 table words, 1 echo bytes
	logic        lo_q, lo_d;
	logic [7:0]  cur_q, cur_d;
	logic [15:0] crcs_q, crcs_d;
	logic        ishold_q, ishold_d;
	logic [16:0] end_w;
	logic [15:0] lim;
	logic [7:0]  dbyte;

	assign fn_hold = ishold_q;
	assign end_w   = {1'b0, sts.start} + {1'b0, sts.qty} - 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mrs_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end
	always_ff @(posedge clk) begin
		sel_q <= sel_d; ptr_q <= ptr_d; len_q <= len_d; bit_q <= bit_d;
		b2_q <= b2_d; fno_q <= fno_d; wi_q <= wi_d; nw_q <= nw_d; dat_q <= dat_d;
		lo_q <= lo_d; cur_q <= cur_d; crcs_q <= crcs_d; ishold_q <= ishold_d;
	end

	always_comb begin
		dbyte = 8'd0;
		if (dat_q) begin
			unique case (wi_q[1:0])
				2'd0: dbyte = sts.start[15:8];
				2'd1: dbyte = sts.start[7:0];
				2'd2: dbyte = sts.qty[15:8];
				default: dbyte = sts.qty[7:0];
			endcase
		end else begin
			dbyte = lo_q ? sts.table_word[7:0] : sts.table_word[15:8];
		end
	end

	always_comb begin
		st_d = st_q; sel_d = sel_q; ptr_d = ptr_q; len_d = len_q; bit_d = bit_q;
		b2_d = b2_q; fno_d = fno_q; wi_d = wi_q; nw_d = nw_q; dat_d = dat_q;
		lo_d = lo_q; cur_d = cur_q; crcs_d = crcs_q; ishold_d = ishold_q;
		cmd = '0;
		in_ready = 1'b0;
		lim = mrs_pkg::MAX_READ_QTY;
		cmd.hold_idx = 5'(wi_q) + sts.start[4:0];
		unique case (st_q)
			mrs_pkg::ST_IDLE: begin
				in_ready = !sts.out_full;
				if (in_valid && !sts.out_full) begin
					unique case (in_op)
						mrs_pkg::OP_RX: begin
							if (sts.enable) begin
								if (!sts.active) begin
									cmd.act_set = 1'b1; cmd.gap_clr = 1'b1;
									cmd.frame_clear = 1'b1; st_d = mrs_pkg::ST_RX;
								end else if (sts.gap) cmd.frame_clear = 1'b1;
								else st_d = mrs_pkg::ST_RX;
							end
						end
						mrs_pkg::OP_TICK: if (sts.active) st_d = mrs_pkg::ST_TICK;
						mrs_pkg::OP_SETIN: cmd.setin = 1'b1;
						default: begin
							ishold_d = 1'b1; st_d = mrs_pkg::ST_RDBACK;
						end
					endcase
				end
			end
			mrs_pkg::ST_RX: begin
				cmd.store_byte = 1'b1; st_d = mrs_pkg::ST_IDLE;
			end
			mrs_pkg::ST_TICK: begin
				cmd.tick = 1'b1;
				st_d = mrs_pkg::ST_IDLE;
				if (!sts.gap) begin
					if (sts.cto_hit) cmd.gap_set = 1'b1;
				end else if (sts.fdly_hit) begin
					if (sts.overflow || sts.count <= 9'd2) begin
						cmd.frame_clear = 1'b1; cmd.gap_clr = 1'b1; cmd.act_clr = 1'b1;
					end else begin
						cmd.crc_init = 1'b1; ptr_d = '0;
						len_d = sts.count - 9'd2; st_d = mrs_pkg::ST_CRC_RD;
					end
					cur_d = 8'd0;
				end
			end
			mrs_pkg::ST_CRC_RD: begin
				if (ptr_q == len_q) begin
					crcs_d = sts.crc; ptr_d = '0; st_d = mrs_pkg::ST_HDR_RD;
				end else begin
					cmd.rd_req = 1'b1; cmd.rd_addr = ptr_q; st_d = mrs_pkg::ST_CRC_BYTE;
				end
			end
			mrs_pkg::ST_CRC_BYTE: begin
				cmd.crc_byte = 1'b1; cmd.out_byte = sts.rd_byte; bit_d = '0;
				st_d = mrs_pkg::ST_CRC_BIT;
			end
			mrs_pkg::ST_CRC_BIT: begin
				cmd.crc_bit = 1'b1; bit_d = bit_q + 4'd1;
				if (bit_q == 4'd7) begin
					ptr_d = ptr_q + 9'd1;
					st_d = cur_q[0] ? mrs_pkg::ST_TX_SEL : mrs_pkg::ST_CRC_RD;
				end
			end
			mrs_pkg::ST_HDR_RD: begin
				cmd.rd_req = 1'b1;
				cmd.rd_addr = (ptr_q == 9'd6) ? len_q : (ptr_q == 9'd7) ? len_q + 9'd1 : ptr_q;
				st_d = mrs_pkg::ST_HDR_LAT;
			end
			mrs_pkg::ST_HDR_LAT: begin
				cmd.hdr_lat = 1'b1; cmd.hdr_slot = ptr_q[2:0];
				ptr_d = ptr_q + 9'd1;
				st_d = (ptr_q == 9'd7) ? mrs_pkg::ST_CHK_RD : mrs_pkg::ST_HDR_RD;
			end
			mrs_pkg::ST_CHK_RD: begin
				cmd.rd_req = 1'b1; cmd.rd_addr = '0; st_d = mrs_pkg::ST_CHK_LAT;
			end
			mrs_pkg::ST_CHK_LAT: begin
				if (crcs_q != sts.crc_rx || sts.rd_byte != sts.slave_addr) begin
					cmd.frame_clear = 1'b1; cmd.gap_clr = 1'b1; cmd.act_clr = 1'b1;
					st_d = mrs_pkg::ST_IDLE;
				end else st_d = mrs_pkg::ST_DECODE;
			end
			mrs_pkg::ST_DECODE: begin
				fno_d = sts.fn; wi_d = '0; lo_d = 1'b0; dat_d = 1'b0; nw_d = '0;
				ishold_d = (sts.fn != mrs_pkg::FN_READ_INPUT);
				st_d = mrs_pkg::ST_TX_SEL; sel_d = mrs_pkg::TXS_ADDR;
				cmd.crc_init = 1'b1;
				if (sts.fn == mrs_pkg::FN_READ_HOLD || sts.fn == mrs_pkg::FN_READ_INPUT ||
				    sts.fn == mrs_pkg::FN_WRITE_HOLD) begin
					if (sts.fn == mrs_pkg::FN_WRITE_HOLD) lim = mrs_pkg::MAX_WRITE_QTY;
					if (sts.qty == 16'd0 || sts.qty > lim) begin
						fno_d = sts.fn | mrs_pkg::EXC_FLAG; b2_d = mrs_pkg::EXC_VALUE;
					end else if (end_w >= 17'((sts.fn == mrs_pkg::FN_READ_INPUT) ?
					                          NUM_INPUT : NUM_HOLDING)) begin
						fno_d = sts.fn | mrs_pkg::EXC_FLAG; b2_d = mrs_pkg::EXC_ADDRESS;
					end else if (sts.fn == mrs_pkg::FN_WRITE_HOLD) begin
						nw_d = sts.qty[6:0]; ptr_d = 9'd7; st_d = mrs_pkg::ST_WR_RD;
						cmd.crc_init = 1'b0;
					end else begin
						b2_d = {sts.qty[6:0], 1'b0}; nw_d = sts.qty[6:0];
					end
				end else begin
					fno_d = sts.fn | mrs_pkg::EXC_FLAG; b2_d = mrs_pkg::EXC_FUNCTION;
				end
			end
			mrs_pkg::ST_WR_RD: begin
				cmd.rd_req = 1'b1; cmd.rd_addr = ptr_q; st_d = mrs_pkg::ST_WR_LAT;
			end
			mrs_pkg::ST_WR_LAT: begin
				cmd.wlat_hi = 1'b1; st_d = mrs_pkg::ST_WR_RD2;
			end
			mrs_pkg::ST_WR_RD2: begin
				cmd.rd_req = 1'b1; cmd.rd_addr = ptr_q + 9'd1; st_d = mrs_pkg::ST_WR_LAT2;
			end
			mrs_pkg::ST_WR_LAT2: begin
				cmd.wlat_lo = 1'b1; st_d = mrs_pkg::ST_WR_LAT2;
				if (lo_q) begin
					cmd.hold_wr = 1'b1; lo_d = 1'b0; wi_d = wi_q + 7'd1;
					ptr_d = ptr_q + 9'd2; cmd.wlat_lo = 1'b0;
					if (wi_q + 7'd1 == nw_q) begin
						st_d = mrs_pkg::ST_TX_SEL; sel_d = mrs_pkg::TXS_ADDR;
						wi_d = '0; dat_d = 1'b1; nw_d = 7'd2; cmd.crc_init = 1'b1;
						b2_d = sts.start[15:8];
					end else st_d = mrs_pkg::ST_WR_RD;
				end else lo_d = 1'b1;
			end
			mrs_pkg::ST_TX_SEL: begin
				// pick next byte, then send it and, unless it is a crc byte, run it through the crc
				unique case (sel_q)
					mrs_pkg::TXS_ADDR: cur_d = sts.slave_addr;
					mrs_pkg::TXS_FN:   cur_d = fno_q;
					mrs_pkg::TXS_B2:   cur_d = b2_q;
					mrs_pkg::TXS_DATA: cur_d = dbyte;
					mrs_pkg::TXS_CRCL: cur_d = crcs_q[7:0];
					default:           cur_d = crcs_q[15:8];
				endcase
				bit_d = 4'd0;
				st_d = mrs_pkg::ST_TX_OUT;
			end
			mrs_pkg::ST_TX_OUT: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1; cmd.out_byte = cur_q;
					cmd.out_last = (sel_q == mrs_pkg::TXS_CRCH);
					st_d = mrs_pkg::ST_IDLE;
					if (sel_q != mrs_pkg::TXS_CRCL && sel_q != mrs_pkg::TXS_CRCH) begin
						cmd.crc_byte = 1'b1;
						st_d = mrs_pkg::ST_CRC_BIT; bit_d = '0;
						cur_d = 8'd1; // return to tx after crc bits
						unique case (sel_q)
							mrs_pkg::TXS_ADDR: sel_d = mrs_pkg::TXS_FN;
							mrs_pkg::TXS_FN: sel_d = (fno_q == mrs_pkg::FN_WRITE_HOLD) ?
								mrs_pkg::TXS_DATA : mrs_pkg::TXS_B2;
							mrs_pkg::TXS_B2: sel_d = (nw_q == '0) ? mrs_pkg::TXS_CRCL :
								mrs_pkg::TXS_DATA;
							default: begin
								sel_d = mrs_pkg::TXS_DATA;
								if (dat_q) begin
									wi_d = wi_q + 7'd1;
									if (wi_q == 7'd3) sel_d = mrs_pkg::TXS_CRCL;
								end else begin
									lo_d = !lo_q;
									if (lo_q) begin
										wi_d = wi_q + 7'd1;
										if (wi_q + 7'd1 == nw_q) sel_d = mrs_pkg::TXS_CRCL;
									end
								end
							end
						endcase
					end else if (sel_q == mrs_pkg::TXS_CRCL) begin
						sel_d = mrs_pkg::TXS_CRCH; st_d = mrs_pkg::ST_TX_SEL;
					end else begin
						// response done, frame ends
						cmd.frame_clear = 1'b1; cmd.gap_clr = 1'b1; cmd.act_clr = 1'b1;
					end
				end
			end
			mrs_pkg::ST_RDBACK: begin
				// readback uses holding table at the item's index
				if (!sts.out_full) begin
					cmd.out_load = 1'b1; cmd.out_kind = 1'b1; cmd.out_last = 1'b1;
					st_d = mrs_pkg::ST_IDLE;
				end
			end
			default: st_d = mrs_pkg::ST_IDLE;
		endcase
		// after crc bits of a tx byte, latch crc for trailer and continue
		if (st_q == mrs_pkg::ST_CRC_BIT && bit_q == 4'd7 && cur_q[0]) begin
			crcs_d = sts.crc[0] ? ((sts.crc >> 1) ^ mrs_pkg::CRC_POLY) : (sts.crc >> 1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_full)
		else $error("result load while full");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != mrs_pkg::ST_IDLE) |-> !in_ready)
		else $error("ready outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hold_wr |-> $past(st_q) == mrs_pkg::ST_WR_LAT2)
		else $error("holding write outside write sequence");
endmodule

@@ hdl/modbus_rtu_slave_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_slave_engine
// modbus rtu slave: frame gapping, crc check, functions 03/04/16
// ----------------------------------------------------------------------------
// readback: result register loads in the cycle after the transfer
// frame end: crc over the bytes ahead of the crc field, header reads and checks, then
//   the response bytes, each run through the crc but the crc bytes, plus stalls
// one item at a time; no transfer is taken while the result register is full
// reset: async active low clears control state, tables and config to defaults
module modbus_rtu_slave_engine #(
	parameter int FRAME_BYTES = 256,
	parameter int NUM_HOLDING = 2,
	parameter int NUM_INPUT   = 3
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [15:0] cfg_data,
	mrs_in_if.sink     item,
	mrs_out_if.source  result
);
	mrs_pkg::dp_cmd_t cmd, cmd_c;
	mrs_pkg::dp_sts_t sts;
	logic             fn_hold;
	logic [4:0]       idx_q;
	logic [7:0]       byte_q;

	mrs_ctrl #(.NUM_HOLDING(NUM_HOLDING), .NUM_INPUT(NUM_INPUT)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(item.valid), .in_ready(item.ready),
		.in_op(item.operation), .fn_hold(fn_hold), .sts(sts), .cmd(cmd_c)
	);

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			idx_q  <= item.reg_index;
			byte_q <= item.rx_byte;
		end
	end

	// readback: drive table index from the latched item index
	always_comb begin
		cmd = cmd_c;
		if (cmd_c.out_kind) cmd.hold_idx = idx_q;
	end

	mrs_datapath #(.FRAME_BYTES(FRAME_BYTES), .NUM_HOLDING(NUM_HOLDING),
		.NUM_INPUT(NUM_INPUT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_byte(byte_q), .in_idx(item.reg_index),
		.in_val(item.reg_value), .in_fn_hold(fn_hold), .cmd(cmd), .sts(sts), .res(result)
	);
endmodule
